[hdl/hnf_pkg.sv]
// ----------------------------------------------------------------------------
// hnf_pkg: shared types and constants for the HDLC NRZI framer
// Operation codes, register indexes, flag limits and the encoder result type.
// ----------------------------------------------------------------------------
`default_nettype none

package hnf_pkg;

    localparam int FLAG_CNT_W = 6;
    localparam int LINE_W     = 10;
    localparam int COUNT_W    = 4;
    localparam int CFG_IDX_W  = 2;

    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_HEAD_FLAGS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_FLAGS = 2'd1;

    localparam logic [FLAG_CNT_W-1:0] HEAD_FLAGS_RESET = 6'd30;
    localparam logic [FLAG_CNT_W-1:0] TAIL_FLAGS_RESET = 6'd3;
    localparam logic [FLAG_CNT_W-1:0] HEAD_FLAGS_FLOOR = 6'd4;
    localparam logic [FLAG_CNT_W-1:0] TAIL_FLAGS_FLOOR = 6'd2;

    localparam logic [2:0] STUFF_AFTER = 3'd5;

    // A flag from level 0 is seven high levels then low; from level 1 the inverse.
    localparam logic [LINE_W-1:0]  FLAG_WORD_LVL0 = 10'h07F;
    localparam logic [LINE_W-1:0]  FLAG_WORD_LVL1 = 10'h080;
    localparam logic [COUNT_W-1:0] FLAG_BITS      = 4'd8;

    typedef struct packed {
        logic [LINE_W-1:0]  line_bits;
        logic [COUNT_W-1:0] bit_count;
        logic               level;
        logic [2:0]         ones_run;
    } enc_result_t;

endpackage

`default_nettype wire

[hdl/hnf_byte_enc.sv]
// ----------------------------------------------------------------------------
// hnf_byte_enc: bit stuffing and NRZI coding of one data byte
// LSB first, a zero inserted after five ones, every bit through NRZI.
// ----------------------------------------------------------------------------
`default_nettype none

module hnf_byte_enc
    import hnf_pkg::*;
(
    input  wire logic [7:0]  data_byte,
    input  wire logic        level_in,
    input  wire logic [2:0]  run_in,
    output enc_result_t      result
);

    always_comb begin
        logic [LINE_W-1:0]  acc;
        logic [COUNT_W-1:0] n;
        logic               lvl;
        logic [2:0]         run;
        acc = '0;
        n   = '0;
        lvl = level_in;
        run = run_in;
        for (int i = 0; i < 8; i++) begin
            if (!data_byte[i]) begin
                lvl = ~lvl;
            end
            acc[n] = lvl;
            n      = n + 4'd1;
            run    = data_byte[i] ? run + 3'd1 : 3'd0;
            if (run >= STUFF_AFTER) begin
                lvl    = ~lvl;
                acc[n] = lvl;
                n      = n + 4'd1;
                run    = 3'd0;
            end
        end
        result.line_bits = acc;
        result.bit_count = n;
        result.level     = lvl;
        result.ones_run  = run;
    end

endmodule

`default_nettype wire

[hdl/hdlc_nrzi_framer_top.sv]
// ----------------------------------------------------------------------------
// hdlc_nrzi_framer_top: HDLC framer with bit stuffing and NRZI line coding
// Input register, flag sequencer and byte encoder, result register.
// ----------------------------------------------------------------------------
// Path: an item waits in the input register, its words in the result register
// driving m_. A data byte gives one word, an ignored operation none, a begin
// frame one flag word per flag (4 to 63), an end frame one per flag (2 to 63).
// Reset: synchronous active-low aresetn clears the line state and the
// valid flags; head_flags returns to 30 and tail_flags to 3.
`default_nettype none

module hdlc_nrzi_framer_top
    import hnf_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [FLAG_CNT_W-1:0] cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [1:0]            s_operation,
    input  wire logic [7:0]            s_data_byte,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [LINE_W-1:0]          m_line_bits,
    output logic [COUNT_W-1:0]         m_bit_count,
    output logic                       m_last
);

    logic [FLAG_CNT_W-1:0] head_flags_reg, tail_flags_reg;
    logic                  in_valid_reg;
    logic [1:0]            op_reg;
    logic [7:0]            byte_reg;
    logic                  line_level_reg, line_level_next;
    logic [2:0]            ones_run_reg, ones_run_next;
    logic [FLAG_CNT_W-1:0] flags_left_reg, flags_left_next;
    logic                  m_valid_reg;
    logic [LINE_W-1:0]     line_bits_reg, line_bits_next;
    logic [COUNT_W-1:0]    bit_count_reg, bit_count_next;
    logic                  last_reg, last_next;

    logic                  out_free, load, consume;
    logic                  flag_lvl;
    logic [FLAG_CNT_W-1:0] flag_cnt, flag_rem;
    enc_result_t           enc;

    hnf_byte_enc u_enc (
        .data_byte (byte_reg),
        .level_in  (line_level_reg),
        .run_in    (ones_run_reg),
        .result    (enc)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        load            = 1'b0;
        consume         = 1'b0;
        line_level_next = line_level_reg;
        ones_run_next   = ones_run_reg;
        flags_left_next = flags_left_reg;
        line_bits_next  = line_bits_reg;
        bit_count_next  = bit_count_reg;
        last_next       = last_reg;
        flag_lvl        = line_level_reg;
        flag_cnt        = flags_left_reg;
        case (op_reg)
            OP_BEGIN: begin
                if (flags_left_reg == '0) begin
                    flag_lvl = 1'b0;
                    flag_cnt = (head_flags_reg < HEAD_FLAGS_FLOOR) ? HEAD_FLAGS_FLOOR
                                                                    : head_flags_reg;
                end
            end
            OP_END: begin
                if (flags_left_reg == '0) begin
                    flag_cnt = (tail_flags_reg < TAIL_FLAGS_FLOOR) ? TAIL_FLAGS_FLOOR
                                                                    : tail_flags_reg;
                end
            end
            default: begin
            end
        endcase
        flag_rem = flag_cnt - 6'd1;
        if (in_valid_reg) begin
            case (op_reg)
                OP_BEGIN, OP_END: begin
                    if (out_free) begin
                        load            = 1'b1;
                        consume         = (flag_rem == '0);
                        line_level_next = flag_lvl;
                        if (op_reg == OP_BEGIN && flags_left_reg == '0) begin
                            ones_run_next = 3'd0;
                        end
                        flags_left_next = flag_rem;
                        line_bits_next  = flag_lvl ? FLAG_WORD_LVL1 : FLAG_WORD_LVL0;
                        bit_count_next  = FLAG_BITS;
                        last_next       = (flag_rem == '0);
                    end
                end
                OP_DATA: begin
                    if (out_free) begin
                        load            = 1'b1;
                        consume         = 1'b1;
                        line_level_next = enc.level;
                        ones_run_next   = enc.ones_run;
                        line_bits_next  = enc.line_bits;
                        bit_count_next  = enc.bit_count;
                        last_next       = 1'b1;
                    end
                end
                default: begin
                    consume = 1'b1;
                end
            endcase
        end
    end

    assign s_ready = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_flags_reg <= HEAD_FLAGS_RESET;
            tail_flags_reg <= TAIL_FLAGS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_HEAD_FLAGS: head_flags_reg <= cfg_data;
                REG_TAIL_FLAGS: tail_flags_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            line_level_reg <= 1'b0;
            ones_run_reg   <= 3'd0;
            flags_left_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (consume) begin
                in_valid_reg <= 1'b0;
            end
            line_level_reg <= line_level_next;
            ones_run_reg   <= ones_run_next;
            flags_left_reg <= flags_left_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= s_operation;
            byte_reg <= s_data_byte;
        end
        line_bits_reg <= line_bits_next;
        bit_count_reg <= bit_count_next;
        last_reg      <= last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_line_bits = line_bits_reg;
    assign m_bit_count = bit_count_reg;
    assign m_last      = last_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_bit_count >= 4'd8 && m_bit_count <= 4'd10))
        else $error("bit_count out of range");

    a_unused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_bit_count == 4'd8) |-> (m_line_bits[9:8] == 2'b00))
        else $error("unused line bits set");

    a_flags_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (flags_left_reg != '0) |-> (in_valid_reg && (op_reg == OP_BEGIN || op_reg == OP_END)))
        else $error("flag run without its operation");

endmodule

`default_nettype wire
